@@ rtl/gle_pkg.sv @@
// Shared constants for the LZW encoder.
`default_nettype none
package gle_pkg;
    localparam int ROOT_CODES  = 256;
    localparam int CLR_CODE    = 256;
    localparam int END_CODE    = 257;
    localparam int START_WIDTH = 9;
    localparam int CODE_W      = 12;
endpackage
`default_nettype wire

@@ rtl/gle_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module gle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/gif_lzw_encoder.sv @@
// Top level: LZW encoder for 8-bit GIF images with a hashed string table.
// An item is looked up in S_CHECK, with a pass through S_LOOK for each extra probe; then its codes
// are queued in S_CODES and packed into bytes in S_SHIFT, where a byte waits while the output stalls.
// A new pixel is taken only in S_IDLE, once the previous one is through.
// The table is cleared by bumping an epoch tag kept with each entry; a sweep over all DICT_ENTRIES
// entries marks every entry free after reset and after the item that uses up the epoch tags.
// Reset: asynchronous, active low; returns the encoder to the start of a new image.
`default_nettype none
module gif_lzw_encoder #(
    parameter int DICT_ENTRIES  = 4096,
    parameter int MAX_CODE_BITS = 12
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] pixel_index,
    input  wire logic       last_pixel,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] out_byte,
    output logic            end_of_run,
    output logic            end_of_image
);
    import gle_pkg::*;

    localparam int AW   = $clog2(DICT_ENTRIES);
    localparam int EPW  = 4;
    // Entry: epoch, prefix code, suffix pixel, code stored there.
    localparam int EW   = EPW + 12 + 8 + 12;
    // The highest tag marks swept entries and is never a live epoch.
    localparam logic [EPW-1:0] EP_SWEPT = '1;

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_LOOK, S_CHECK, S_CODES, S_SHIFT
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     sweep_reg;
    logic              sweep_pend_reg;
    logic [EPW-1:0]    epoch_reg;
    logic [12:0]       next_code_reg;
    logic [3:0]        width_reg;
    logic [11:0]       prefix_reg;
    logic              started_reg;
    logic [7:0]        px_reg;
    logic              last_reg;
    logic [AW-1:0]     hash_reg;
    // Queue of up to four codes to pack: code and its width.
    logic [11:0]       q_code_reg [4];
    logic [3:0]        q_w_reg [4];
    logic [2:0]        q_n_reg;
    logic [2:0]        q_i_reg;
    logic              q_flush_reg;
    logic [19:0]       acc_reg;
    logic [4:0]        cnt_reg;
    logic [7:0]        ob_reg;
    logic              oeor_reg;
    logic              oeoi_reg;
    logic              ov_reg;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [EW-1:0]     wdata;
    logic [EW-1:0]     rdata;
    logic [AW-1:0]     raddr;

    gle_ram #(.WIDTH(EW), .DEPTH(DICT_ENTRIES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // Hash of prefix and pixel folded to the table address.
    function automatic logic [AW-1:0] hash_f(input logic [11:0] p, input logic [7:0] s);
        logic [19:0] h;
        h = {s, p} ^ {p, 8'd0} ^ {8'd0, s, 4'd0};
        return h[AW-1:0] ^ h[19 -: AW];
    endfunction

    logic [AW-1:0] hash_now;
    assign hash_now = hash_f(prefix_reg, pixel_index);

    logic [EPW-1:0] r_ep;
    logic [11:0]    r_pre;
    logic [7:0]     r_suf;
    logic [11:0]    r_code;
    assign {r_ep, r_pre, r_suf, r_code} = rdata;

    logic hit, empty;
    assign hit   = (r_ep == epoch_reg) && (r_pre == prefix_reg) && (r_suf == px_reg);
    assign empty = (r_ep != epoch_reg);

    // Next epoch tag; running out of tags calls for a sweep.
    logic           ep_wrap;
    logic [EPW-1:0] ep_inc;
    assign ep_wrap = (epoch_reg == EP_SWEPT - EPW'(1));
    assign ep_inc  = ep_wrap ? '0 : epoch_reg + EPW'(1);

    logic [12:0] nc_inc;
    logic [12:0] top;
    logic        full, grow;
    assign nc_inc = next_code_reg + 13'd1;
    assign top    = (13'd1 << width_reg) - 13'd1;
    assign full   = (nc_inc >= 13'(DICT_ENTRIES))
                 || ((nc_inc > top) && (width_reg >= 4'(MAX_CODE_BITS)));
    assign grow   = (nc_inc > top);

    // Probe address follows the hash, stepping linearly on collision.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            raddr = hash_now;
        end
        else if (state_reg == S_CHECK)
        begin
            raddr = hash_reg + AW'(1);
        end
        else
        begin
            raddr = hash_reg;
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = hash_reg;
        wdata = {epoch_reg, prefix_reg, px_reg, next_code_reg[11:0] + 12'd1};
        if (state_reg == S_SWEEP)
        begin
            we    = 1'b1;
            waddr = sweep_reg;
            wdata = {EP_SWEPT, 32'd0};
        end
        else if (state_reg == S_CHECK && started_reg && empty && !full)
        begin
            we = 1'b1;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = ov_reg;
    assign out_byte     = ob_reg;
    assign end_of_run   = oeor_reg;
    assign end_of_image = oeoi_reg;

    logic [19:0] acc_add;
    logic [4:0]  cnt_add;
    always_comb
    begin
        acc_add = acc_reg | (20'(q_code_reg[q_i_reg[1:0]] & 12'((13'd1 << q_w_reg[q_i_reg[1:0]]) - 13'd1))
                  << cnt_reg);
        cnt_add = cnt_reg + 5'(q_w_reg[q_i_reg[1:0]]);
    end

    // A new byte enters the output register in this cycle.
    logic byte_go;
    assign byte_go = (state_reg == S_SHIFT) && (!ov_reg || out_ready)
                  && ((cnt_reg >= 5'd8)
                      || ((q_i_reg == q_n_reg) && q_flush_reg && (cnt_reg != 5'd0)));

    // Main sequencer: sweep, lookup, insert, queue codes, pack bytes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            sweep_reg      <= '0;
            sweep_pend_reg <= 1'b0;
            epoch_reg      <= '0;
            next_code_reg  <= 13'(END_CODE);
            width_reg      <= 4'(START_WIDTH);
            prefix_reg     <= '0;
            started_reg    <= 1'b0;
            px_reg         <= '0;
            last_reg       <= 1'b0;
            hash_reg       <= '0;
            for (int i = 0; i < 4; i++)
            begin
                q_code_reg[i] <= '0;
                q_w_reg[i]    <= '0;
            end
            q_n_reg        <= '0;
            q_i_reg        <= '0;
            q_flush_reg    <= 1'b0;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            ob_reg         <= '0;
            oeor_reg       <= 1'b0;
            oeoi_reg       <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready && !byte_go)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_SWEEP:
                begin
                    if (sweep_reg == AW'(DICT_ENTRIES - 1))
                    begin
                        sweep_reg      <= '0;
                        sweep_pend_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + AW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        px_reg    <= pixel_index;
                        last_reg  <= last_pixel;
                        hash_reg  <= hash_now;
                        q_n_reg   <= '0;
                        q_i_reg   <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    hash_reg <= hash_reg + AW'(1);
                    if (!started_reg)
                    begin
                        epoch_reg     <= ep_inc;
                        if (ep_wrap)
                        begin
                            sweep_pend_reg <= 1'b1;
                        end
                        next_code_reg <= 13'(END_CODE);
                        width_reg     <= 4'(START_WIDTH);
                        q_code_reg[0] <= 12'(CLR_CODE);
                        q_w_reg[0]    <= 4'(START_WIDTH);
                        q_n_reg       <= 3'd1;
                        prefix_reg    <= {4'd0, px_reg};
                        started_reg   <= 1'b1;
                        state_reg     <= S_CODES;
                    end
                    else if (hit)
                    begin
                        prefix_reg <= r_code;
                        state_reg  <= S_CODES;
                    end
                    else if (empty)
                    begin
                        q_code_reg[0] <= prefix_reg;
                        q_w_reg[0]    <= width_reg;
                        prefix_reg    <= {4'd0, px_reg};
                        state_reg     <= S_CODES;
                        if (full)
                        begin
                            q_code_reg[1] <= 12'(CLR_CODE);
                            q_w_reg[1]    <= width_reg;
                            q_n_reg       <= 3'd2;
                            epoch_reg     <= ep_inc;
                            if (ep_wrap)
                            begin
                                sweep_pend_reg <= 1'b1;
                            end
                            next_code_reg <= 13'(END_CODE);
                            width_reg     <= 4'(START_WIDTH);
                        end
                        else
                        begin
                            q_n_reg       <= 3'd1;
                            next_code_reg <= nc_inc;
                            if (grow)
                            begin
                                width_reg <= width_reg + 4'd1;
                            end
                        end
                    end
                    else
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_CODES:
                begin
                    // Append the closing codes for the last pixel.
                    q_flush_reg <= last_reg;
                    if (last_reg)
                    begin
                        q_code_reg[q_n_reg[1:0]]        <= prefix_reg;
                        q_w_reg[q_n_reg[1:0]]           <= width_reg;
                        q_code_reg[q_n_reg[1:0] + 2'd1] <= 12'(END_CODE);
                        q_w_reg[q_n_reg[1:0] + 2'd1]    <= width_reg;
                        q_n_reg                         <= q_n_reg + 3'd2;
                    end
                    state_reg   <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        if (cnt_reg >= 5'd8)
                        begin
                            ob_reg   <= acc_reg[7:0];
                            acc_reg  <= acc_reg >> 8;
                            cnt_reg  <= cnt_reg - 5'd8;
                            ov_reg   <= 1'b1;
                            oeor_reg <= (q_i_reg == q_n_reg) && (cnt_reg < 5'd16)
                                     && !(q_flush_reg && cnt_reg != 5'd8);
                            oeoi_reg <= q_flush_reg && (q_i_reg == q_n_reg) && (cnt_reg == 5'd8);
                        end
                        else if (q_i_reg != q_n_reg)
                        begin
                            acc_reg <= acc_add;
                            cnt_reg <= cnt_add;
                            q_i_reg <= q_i_reg + 3'd1;
                        end
                        else if (q_flush_reg && cnt_reg != 5'd0)
                        begin
                            ob_reg   <= acc_reg[7:0];
                            acc_reg  <= '0;
                            cnt_reg  <= '0;
                            ov_reg   <= 1'b1;
                            oeor_reg <= 1'b1;
                            oeoi_reg <= 1'b1;
                        end
                        else
                        begin
                            if (q_flush_reg)
                            begin
                                epoch_reg     <= ep_inc;
                                if (ep_wrap)
                                begin
                                    sweep_pend_reg <= 1'b1;
                                end
                                next_code_reg <= 13'(END_CODE);
                                width_reg     <= 4'(START_WIDTH);
                                prefix_reg    <= '0;
                                started_reg   <= 1'b0;
                                acc_reg       <= '0;
                                cnt_reg       <= '0;
                                q_flush_reg   <= 1'b0;
                            end
                            // Retag the whole table once the epoch tags are used up.
                            if (sweep_pend_reg || (q_flush_reg && ep_wrap))
                            begin
                                state_reg <= S_SWEEP;
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ tb/tb_gif_lzw_encoder.sv @@
// Self-checking testbench for the GIF LZW encoder: table-driven and random images.
`default_nettype none
module tb_gif_lzw_encoder;
    import gle_pkg::*;

    localparam int DICT_N    = 4096;
    localparam int MAX_BITS  = 12;
    localparam int CYCLE_CAP = 600000;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       image_end;
    } byte_t;

    typedef struct {
        logic [7:0] px;
        logic       last;
        int         n_known;
        logic [7:0] known [4];
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] pixel_index = '0;
    logic       last_pixel = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_image;

    // Encoder state mirror.
    logic [11:0] tbl_prefix [DICT_N];
    logic [7:0]  tbl_suffix [DICT_N];
    bit          tbl_used [DICT_N];
    int          tbl_next;
    int          code_bits;
    logic [11:0] cur_string;
    logic [7:0]  pend_bits;
    int          pend_count;
    bit          in_image;

    byte_t stream_bytes [$];
    byte_t bytes_due [$];
    int    errors = 0;
    int    cycles = 0;
    int    hold_off = 0;
    bit    hold_req = 1'b0;
    bit    hold_seen = 1'b0;
    bit    calm = 1'b0;

    gif_lzw_encoder dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pixel_index(pixel_index), .last_pixel(last_pixel),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_byte(out_byte), .end_of_run(end_of_run), .end_of_image(end_of_image)
    );

    always #10 clk = ~clk;

    // Pack one code into the byte stream, least significant bit first.
    task automatic pack_code(input int code);
        logic [31:0] v;
        int          bits;
        begin
            v = {24'd0, pend_bits} | ((code & ((1 << code_bits) - 1)) << pend_count);
            bits = pend_count + code_bits;
            while (bits >= 8)
            begin
                stream_bytes.push_back('{v[7:0], 1'b0, 1'b0});
                v = v >> 8;
                bits -= 8;
            end
            pend_bits = v[7:0];
            pend_count = bits;
        end
    endtask

    task automatic empty_table();
        begin
            foreach (tbl_used[i]) tbl_used[i] = 1'b0;
            tbl_next = END_CODE;
            code_bits = START_WIDTH;
        end
    endtask

    function automatic int lookup_string(input logic [11:0] pre, input logic [7:0] suf);
        for (int c = END_CODE + 1; c <= tbl_next && c < DICT_N; c++)
            if (tbl_used[c] && tbl_prefix[c] == pre && tbl_suffix[c] == suf)
                return c;
        return -1;
    endfunction

    // Add a string; a full table sends a clear code and starts over at 9 bits.
    task automatic grow_table(input logic [11:0] pre, input logic [7:0] suf);
        int top;
        begin
            top = (1 << code_bits) - 1;
            tbl_next++;
            if (tbl_next < DICT_N)
            begin
                tbl_prefix[tbl_next] = pre;
                tbl_suffix[tbl_next] = suf;
                tbl_used[tbl_next] = 1'b1;
            end
            if (tbl_next >= DICT_N || (tbl_next > top && code_bits >= MAX_BITS))
            begin
                pack_code(CLR_CODE);
                empty_table();
            end
            else if (tbl_next > top)
                code_bits++;
        end
    endtask

    // Compute the bytes one pixel produces into stream_bytes.
    task automatic encode_pixel(input logic [7:0] px, input logic last);
        int hit;
        begin
            stream_bytes.delete();
            if (!in_image)
            begin
                empty_table();
                pack_code(CLR_CODE);
                in_image = 1'b1;
                cur_string = {4'd0, px};
            end
            else
            begin
                hit = lookup_string(cur_string, px);
                if (hit >= 0)
                    cur_string = hit[11:0];
                else
                begin
                    pack_code(cur_string);
                    grow_table(cur_string, px);
                    cur_string = {4'd0, px};
                end
            end
            if (last)
            begin
                pack_code(cur_string);
                pack_code(END_CODE);
                if (pend_count > 0)
                    stream_bytes.push_back('{pend_bits, 1'b0, 1'b0});
                if (stream_bytes.size() > 0)
                    stream_bytes[$].image_end = 1'b1;
                empty_table();
                cur_string = '0;
                pend_bits = '0;
                pend_count = 0;
                in_image = 1'b0;
            end
            if (stream_bytes.size() > 0)
                stream_bytes[$].run_end = 1'b1;
        end
    endtask

    // Offer one item after an optional gap; record its bytes when accepted.
    task automatic send_pixel(input logic [7:0] px, input logic last, input int n_known,
                              input logic [7:0] known [4]);
        int gap;
        begin
            gap = (!calm && $urandom_range(99) < 32) ? $urandom_range(1, 5) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            pixel_index <= px;
            last_pixel <= last;
            do @(posedge clk); while (!in_ready);
            encode_pixel(px, last);
            if (n_known > 0)
            begin
                for (int i = 0; i < n_known; i++)
                    bytes_due.push_back('{known[i], i == n_known - 1, last && i == n_known - 1});
            end
            else
                foreach (stream_bytes[i]) bytes_due.push_back(stream_bytes[i]);
        end
    endtask

    task automatic send_random(input logic [7:0] px, input logic last);
        logic [7:0] none [4];
        begin
            none = '{default: '0};
            send_pixel(px, last, 0, none);
        end
    endtask

    // Hold the input until every pending byte has come out.
    task automatic drain();
        begin
            in_valid <= 1'b0;
            while (bytes_due.size() > 0) @(posedge clk);
            repeat (12) @(posedge clk);
        end
    endtask

    // Random image; a small alphabet makes long matching strings.
    task automatic send_image(input int len, input int alphabet);
        begin
            for (int i = 0; i < len; i++)
                send_random($urandom_range(alphabet - 1), i == len - 1);
        end
    endtask

    // Receiver with random stalls and one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_off <= 400;
            out_ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 32);
    end

    // Compare each accepted byte with the oldest prediction.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (bytes_due.size() == 0)
            begin
                $error("unexpected byte %h", out_byte);
                errors++;
            end
            else
            begin
                byte_t want;
                want = bytes_due.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte expected %h got %h", want.data, out_byte);
                    errors++;
                end
                if (end_of_run !== want.run_end)
                begin
                    $error("end_of_run expected %b got %b", want.run_end, end_of_run);
                    errors++;
                end
                if (end_of_image !== want.image_end)
                begin
                    $error("end_of_image expected %b got %b", want.image_end, end_of_image);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    row_t rows [$];

    initial
    begin
        // Single-pixel images have bytes that are easy to work out by hand.
        rows.push_back('{8'h00, 1'b1, 4, '{8'h00, 8'h01, 8'h04, 8'h04}});
        rows.push_back('{8'hFF, 1'b1, 4, '{8'h00, 8'hFF, 8'h05, 8'h04}});
        // A run of one color builds ever longer strings.
        for (int i = 0; i < 8; i++)
            rows.push_back('{8'h07, i == 7, 0, '{default: '0}});
        // Alternating extremes, then a two-pixel image of two other values.
        for (int i = 0; i < 10; i++)
            rows.push_back('{(i % 2) ? 8'hFF : 8'h00, i == 9, 0, '{default: '0}});
        rows.push_back('{8'hA5, 1'b0, 0, '{default: '0}});
        rows.push_back('{8'h5A, 1'b1, 0, '{default: '0}});

        in_image = 1'b0;
        pend_bits = '0;
        pend_count = 0;
        cur_string = '0;
        empty_table();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[r]) send_pixel(rows[r].px, rows[r].last, rows[r].n_known, rows[r].known);

        // Random images of mostly short length.
        for (int k = 0; k < 4; k++)
            send_image($urandom_range(1, 20), ($urandom_range(3) == 0) ? 256 : 4);

        // Receiver holds off long enough for the encoder to back up.
        hold_req = 1'b1;
        send_image(30, 3);
        drain();

        // A stretch without any idling.
        calm = 1'b1;
        send_image(30, 8);
        calm = 1'b0;

        // One long image of varied pixels grows the codes past 9 bits.
        send_image(270, 256);

        drain();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/gle_pkg.sv
rtl/gle_ram.sv
rtl/gif_lzw_encoder.sv
tb/tb_gif_lzw_encoder.sv
